// ----- rtl/kft_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kft_pkg
// Shared sizes, types and state codes of the k-th largest frequency tracker.
// ----------------------------------------------------------------------------
package kft_pkg;

    // number of elements and of distinct values
    localparam int ELEMENTS = 1024;
    localparam int VALUES   = 1024;

    // widths that follow from the sizes
    localparam int IDX_W = $clog2(ELEMENTS);
    localparam int VAL_W = $clog2(VALUES);
    localparam int CNT_W = $clog2(ELEMENTS + 1);

    // per-value store is also the per-element flag store, one word per address
    localparam int CELL_DEPTH = (ELEMENTS > VALUES) ? ELEMENTS : VALUES;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int CELL_W     = CNT_W + 1;

    // at-least store holds entries 1..ELEMENTS at address c-1
    localparam int ALC_DEPTH = ELEMENTS;
    localparam int ALC_AW    = $clog2(ALC_DEPTH);

    // beat layout
    localparam int S_TDATA_W = ((IDX_W + VAL_W + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST = CNT_W'(ELEMENTS);

    // item kinds carried in tuser
    localparam logic MODE_TOGGLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_T_FLAG,
        S_T_CNT,
        S_T_UPD,
        S_Q_RD,
        S_Q_CMP
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/kth_largest_frequency_tracker_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kth_largest_frequency_tracker_unit
// Toggles elements in and out of a multiset and answers k-th largest
// frequency queries from a store of "values occurring at least c times".
// ----------------------------------------------------------------------------
// Usage
//   slave stream: one beat per item; tuser is the mode (toggle or query),
//   tdata carries element index, element value and rank k.
//   master stream: one beat per query holding the answer; toggles give none.
//   cfg: i_cfg_we writes the search bound max_count (values above the element
//   count act as the element count); write it only while the block is idle.
// Operation
//   a toggle is a read-modify-write on the two memories, in order: element
//   word read, value word read, count write-back with at-least entry read,
//   flag and at-least entry write-back.
//   a query is a binary search, each step a memory read and then a compare,
//   at most log2(ELEMENTS)+1 steps.
//   one item is in work at a time; the registered read port of the
//   at-least memory sets the step time.
// Reset
//   after reset both memories are cleared, one address per cycle, over all
//   1024 addresses; tready stays low during that pass, cfg writes are still taken.
// Stall
//   the answer waits in an output register; a toggle can still be taken
//   while it waits, a further query holds at its last step until it drains.
// ----------------------------------------------------------------------------
module kth_largest_frequency_tracker_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: element_index, element_value, rank_k, zero fill
    input  wire logic [kft_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode
    input  wire logic                          i_s_axis_tuser,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: answer, zero fill
    output logic [kft_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [kft_pkg::CNT_W-1:0]     i_cfg_wdata
);
    import kft_pkg::*;

    // memories: flag plus count per address, and at-least counts
    logic [CELL_W-1:0] r_cell_mem [CELL_DEPTH];
    logic [CNT_W-1:0]  r_alc_mem  [ALC_DEPTH];
    logic [CELL_W-1:0] r_cell_rdata;
    logic [CNT_W-1:0]  r_alc_rdata;

    t_state r_state, n_state;
    logic [CELL_AW-1:0] r_clr;
    logic [CNT_W-1:0]   r_max_count;

    // item payload
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_k;

    // toggle working registers
    logic [CELL_W-1:0] r_idx_word, n_idx_word;
    logic              r_new_flag, n_new_flag;
    logic [CNT_W-1:0]  r_cnt_new, n_cnt_new;
    logic              r_alc_chg, n_alc_chg;
    logic              r_alc_inc, n_alc_inc;
    logic [ALC_AW-1:0] r_alc_addr, n_alc_addr;

    // search registers
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_answer, n_answer;

    // memory port controls
    logic               cell_re, cell_we;
    logic [CELL_AW-1:0] cell_raddr, cell_waddr;
    logic [CELL_W-1:0]  cell_wdata;
    logic               alc_re, alc_we;
    logic [ALC_AW-1:0]  alc_raddr, alc_waddr;
    logic [CNT_W-1:0]   alc_wdata;

    logic             s_accept;
    logic             out_free;
    logic             same_addr;
    logic [CNT_W-1:0] cur_cnt;
    logic             cur_flag;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] bound;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign same_addr       = (CELL_AW'(r_idx) == CELL_AW'(r_val));
    assign cur_cnt         = r_cell_rdata[CNT_W-1:0];
    assign cur_flag        = r_cell_rdata[CNT_W];
    assign sum             = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid             = sum[CNT_W:1];
    assign bound           = (r_max_count > CNT_W'(ELEMENTS)) ? CNT_W'(ELEMENTS)
                                                              : r_max_count;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_answer);

    // cell memory
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re) begin
            r_cell_rdata <= r_cell_mem[cell_raddr];
        end
    end

    // at-least memory
    always_ff @(posedge i_clk) begin
        if (alc_we) begin
            r_alc_mem[alc_waddr] <= alc_wdata;
        end
        if (alc_re) begin
            r_alc_rdata <= r_alc_mem[alc_raddr];
        end
    end

    // control state, clearing pass and search bound register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_max_count <= MAX_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_max_count <= i_cfg_wdata;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_idx <= i_s_axis_tdata[IDX_W-1:0];
            r_val <= i_s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
            r_k   <= i_s_axis_tdata[IDX_W+VAL_W+CNT_W-1:IDX_W+VAL_W];
        end
        r_idx_word <= n_idx_word;
        r_new_flag <= n_new_flag;
        r_cnt_new  <= n_cnt_new;
        r_alc_chg  <= n_alc_chg;
        r_alc_inc  <= n_alc_inc;
        r_alc_addr <= n_alc_addr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_answer   <= n_answer;
    end

    // next state, memory accesses and search steps
    always_comb begin
        n_state     = r_state;
        n_idx_word  = r_idx_word;
        n_new_flag  = r_new_flag;
        n_cnt_new   = r_cnt_new;
        n_alc_chg   = r_alc_chg;
        n_alc_inc   = r_alc_inc;
        n_alc_addr  = r_alc_addr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_answer    = r_answer;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        cell_re     = 1'b0;
        cell_raddr  = CELL_AW'(r_idx);
        cell_we     = 1'b0;
        cell_waddr  = r_clr;
        cell_wdata  = '0;
        alc_re      = 1'b0;
        alc_raddr   = mid[ALC_AW-1:0];
        alc_we      = 1'b0;
        alc_waddr   = r_clr[ALC_AW-1:0];
        alc_wdata   = '0;

        case (r_state)
            S_CLEAR: begin
                cell_we = 1'b1;
                alc_we  = 1'b1;
                if (r_clr == CELL_AW'(CELL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_axis_tuser == MODE_TOGGLE) begin
                        cell_re    = 1'b1;
                        cell_raddr = CELL_AW'(i_s_axis_tdata[IDX_W-1:0]);
                        n_state    = S_T_FLAG;
                    end else begin
                        n_lo    = '0;
                        n_hi    = bound;
                        n_state = S_Q_RD;
                    end
                end
            end
            // element word is back: keep it, fetch the value word
            S_T_FLAG: begin
                n_idx_word = r_cell_rdata;
                cell_re    = 1'b1;
                cell_raddr = CELL_AW'(r_val);
                n_state    = S_T_CNT;
            end
            // value count is back: update it and fetch the at-least entry
            S_T_CNT: begin
                n_cnt_new = cur_cnt;
                n_alc_chg = 1'b0;
                n_alc_inc = 1'b0;
                if (r_idx_word[CNT_W]) begin
                    n_new_flag = 1'b0;
                    if (cur_cnt != '0) begin
                        n_cnt_new  = cur_cnt - 1'b1;
                        n_alc_chg  = 1'b1;
                        n_alc_addr = n_cnt_new[ALC_AW-1:0];
                    end
                end else begin
                    n_new_flag = 1'b1;
                    if (cur_cnt < CNT_W'(ELEMENTS)) begin
                        n_cnt_new  = cur_cnt + 1'b1;
                        n_alc_chg  = 1'b1;
                        n_alc_inc  = 1'b1;
                        n_alc_addr = cur_cnt[ALC_AW-1:0];
                    end
                end
                alc_re     = n_alc_chg;
                alc_raddr  = n_alc_addr;
                cell_we    = 1'b1;
                cell_waddr = CELL_AW'(r_val);
                cell_wdata = {(same_addr ? n_new_flag : cur_flag), n_cnt_new};
                n_state    = S_T_UPD;
            end
            // write back the element flag and the at-least entry
            S_T_UPD: begin
                cell_we    = 1'b1;
                cell_waddr = CELL_AW'(r_idx);
                cell_wdata = {r_new_flag,
                              (same_addr ? r_cnt_new : r_idx_word[CNT_W-1:0])};
                alc_we     = r_alc_chg;
                alc_waddr  = r_alc_addr;
                alc_wdata  = r_alc_inc ? (r_alc_rdata + 1'b1) : (r_alc_rdata - 1'b1);
                n_state    = S_IDLE;
            end
            // search step: probe entry mid+1 or finish
            S_Q_RD: begin
                if (r_lo < r_hi) begin
                    alc_re  = 1'b1;
                    n_mid   = mid;
                    n_state = S_Q_CMP;
                end else if (out_free) begin
                    n_answer    = r_lo;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_Q_CMP: begin
                if (r_alc_rdata >= r_k) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_Q_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("item taken during clearing pass");

    a_search_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_CMP) |-> (r_lo < r_hi))
        else $error("search step with an empty range");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_RD) |-> (r_hi <= CNT_W'(ELEMENTS)))
        else $error("search bound above element count");

    a_count_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_UPD) |-> (r_cnt_new <= CNT_W'(ELEMENTS)))
        else $error("value count above element count");

    a_answer_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_answer)))
        else $error("pending answer lost");

endmodule
`default_nettype wire

// ----- test/tb_kth_largest_frequency_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kth_largest_frequency_tracker_unit
// Self-checking bench for the k-th largest frequency tracker. A short table
// of toggle and query beats comes first, then random traffic under several
// search bounds, including zero and a bound above the element count.
// Every answer beat is compared with a frequency predictor kept in the bench,
// or with the answer typed into the table where one is given.
module tb_kth_largest_frequency_tracker_unit;

    import kft_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int POOL           = 48;
    localparam int VAL_POOL       = 12;
    localparam int PHASE_ITEMS    = 90;
    localparam int DIR_ROWS       = 20;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] k;
        logic             fixed;
        logic [CNT_W-1:0] answer;
    } t_stim_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 s_tvalid        = 1'b0;
    logic                 s_tuser         = MODE_TOGGLE;
    logic [S_TDATA_W-1:0] s_tdata         = '0;
    logic                 m_tready        = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata       = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    // predictor state
    logic                 present_q   [ELEMENTS];
    logic [CNT_W-1:0]     value_cnt   [VALUES];
    logic [CNT_W-1:0]     atleast_cnt [ELEMENTS+1];
    logic [CNT_W-1:0]     search_bound = CNT_W'(ELEMENTS);

    logic [CNT_W-1:0]     pending_answers [$];
    logic                 quiet = 1'b0;
    int                   err_count  = 0;
    int                   n_toggles  = 0;
    int                   n_queries  = 0;
    int                   n_answers  = 0;
    int                   n_writes   = 0;
    int                   idle_count = 0;

    logic [IDX_W-1:0]     elem_ids  [POOL];
    logic [VAL_W-1:0]     elem_vals [POOL];
    logic [VAL_W-1:0]     val_pool  [VAL_POOL];

    // directed beats; answers typed in only where they are obvious
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{MODE_QUERY,  10'd0,    10'd0,    11'd0,    1'b1, 11'd1024},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd1,    1'b1, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd1024, 1'b1, 11'd0},
        '{MODE_TOGGLE, 10'd0,    10'd0,    11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd1,    10'd0,    11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd2,    10'd1023, 11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd1023, 10'd1023, 11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd1022, 10'd1023, 11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd5,    10'd512,  11'd0,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd1,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd2,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd3,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd4,    1'b0, 11'd0},
        // removal under a value whose count is zero
        '{MODE_TOGGLE, 10'd0,    10'd7,    11'd0,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd1,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd0,    10'd0,    11'd0,    1'b0, 11'd0},
        '{MODE_TOGGLE, 10'd1,    10'd0,    11'd0,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd2,    1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd1024, 1'b0, 11'd0},
        '{MODE_QUERY,  10'd0,    10'd0,    11'd0,    1'b1, 11'd1024}
    };

    kth_largest_frequency_tracker_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // largest m within the bound such that at least k values occur at least m times
    function automatic logic [CNT_W-1:0] kth_frequency(input logic [CNT_W-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = search_bound;
        if (hi > ELEMENTS) hi = ELEMENTS;
        while (lo < hi) begin
            mid = ((lo + hi) >> 1) + 1;
            if (atleast_cnt[mid] >= k) lo = mid;
            else hi = mid - 1;
        end
        return CNT_W'(lo);
    endfunction

    // membership flip and count bookkeeping
    task automatic update_counts(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        int c;
        c = value_cnt[val];
        if (present_q[idx]) begin
            if (c > 0) begin
                atleast_cnt[c] = atleast_cnt[c] - 1'b1;
                value_cnt[val] = CNT_W'(c - 1);
            end
            present_q[idx] = 1'b0;
        end else begin
            if (c < ELEMENTS) begin
                value_cnt[val]     = CNT_W'(c + 1);
                atleast_cnt[c + 1] = atleast_cnt[c + 1] + 1'b1;
            end
            present_q[idx] = 1'b1;
        end
    endtask

    task automatic report(input string what, input logic [CNT_W-1:0] want,
                          input logic [CNT_W-1:0] got);
        err_count++;
        $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // one slave beat, with a random idle gap ahead of it
    task automatic drive_item(input logic mode, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic [CNT_W-1:0] k,
                              input logic fixed, input logic [CNT_W-1:0] fixed_ans);
        int   gap;
        logic acc;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 32) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'({k, val, idx});
        do begin
            @(negedge i_clk);
            acc = o_s_axis_tready;
            @(posedge i_clk);
        end while (!acc);
        if (mode == MODE_QUERY) begin
            pending_answers.push_back(fixed ? fixed_ans : kth_frequency(k));
            n_queries++;
        end else begin
            update_counts(idx, val);
            n_toggles++;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // new search bound, written with the block idle
    task automatic set_bound(input logic [CNT_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        search_bound = v;
        n_writes++;
    endtask

    // random beat: queries, mostly consistent toggles of a small pool, some noise
    task automatic random_item();
        int               r;
        int               e;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] k;
        r   = $urandom_range(0, 99);
        e   = $urandom_range(0, POOL - 1);
        idx = IDX_W'($urandom);
        val = VAL_W'($urandom);
        k   = CNT_W'($urandom);
        if (r < 35) begin
            if ($urandom_range(0, 9) != 0) k = CNT_W'($urandom_range(0, 12));
            drive_item(MODE_QUERY, idx, val, k, 1'b0, '0);
        end else if (r < 88) begin
            drive_item(MODE_TOGGLE, elem_ids[e], elem_vals[e], k, 1'b0, '0);
        end else if (r < 94) begin
            drive_item(MODE_TOGGLE, elem_ids[e], val, k, 1'b0, '0);
        end else begin
            drive_item(MODE_TOGGLE, idx, val, k, 1'b0, '0);
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    // answer check and watchdog, sampled on the falling edge, ahead of the rising edge
    always @(negedge i_clk) begin
        logic [CNT_W-1:0] want;
        logic             fire;
        fire = 1'b0;
        if (i_rst_n && s_tvalid && o_s_axis_tready) fire = 1'b1;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            fire = 1'b1;
            n_answers++;
            if (pending_answers.size() == 0) begin
                report("answer beat with none outstanding", '0, o_m_axis_tdata[CNT_W-1:0]);
            end else begin
                want = pending_answers.pop_front();
                if (o_m_axis_tdata[CNT_W-1:0] !== want)
                    report("answer", want, o_m_axis_tdata[CNT_W-1:0]);
            end
        end
        if (fire) idle_count = 0;
        else idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0] bounds [5];

        for (int i = 0; i < ELEMENTS; i++) present_q[i] = 1'b0;
        for (int i = 0; i < VALUES; i++) value_cnt[i] = '0;
        for (int i = 0; i <= ELEMENTS; i++) atleast_cnt[i] = '0;
        for (int i = 0; i < VAL_POOL; i++) val_pool[i] = VAL_W'($urandom);
        for (int i = 0; i < POOL; i++) begin
            elem_ids[i]  = IDX_W'($urandom);
            elem_vals[i] = val_pool[$urandom_range(0, VAL_POOL - 1)];
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset bound still in force
        for (int i = 0; i < DIR_ROWS; i++) begin
            drive_item(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val,
                       dir_rows[i].k, dir_rows[i].fixed, dir_rows[i].answer);
        end

        // random traffic under several bounds, one phase without stalls
        bounds = '{11'd0, 11'd2047, 11'd3, CNT_W'($urandom_range(1, 1023)), 11'd1024};
        for (int p = 0; p < 5; p++) begin
            set_bound(bounds[p]);
            quiet = (p == 1);
            for (int i = 0; i < PHASE_ITEMS; i++) random_item();
        end
        quiet = 1'b0;

        drain();
        while (pending_answers.size() > 0) begin
            report("answer never delivered", pending_answers.pop_front(), '0);
        end

        $display("covered %0d toggle and %0d query beats, %0d answers checked",
                 n_toggles, n_queries, n_answers);
        $display("search bound written %0d times, from zero to above the element count",
                 n_writes);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kft_pkg.sv
rtl/kth_largest_frequency_tracker_unit.sv
test/tb_kth_largest_frequency_tracker_unit.sv
